[hw/rtl/irtp_pkg.sv]
// ----------------------------------------------------------------------------
// irtp_pkg
// Shared types and constants of the two-point IR tracker.
// ----------------------------------------------------------------------------
package irtp_pkg;

	localparam int unsigned CfgIdxW = 2;

	typedef enum logic [CfgIdxW-1:0] {
		REG_RADIUS   = 2'd0,
		REG_MAX_SAMP = 2'd1,
		REG_MIN_SAMP = 2'd2,
		REG_WEIGHT   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic       start;
		logic       signed_op;
		logic [5:0] num_w;
	} div_req_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SEL,
		ST_PAIR,
		ST_FIX,
		ST_MX_DIV,
		ST_MX_WAIT,
		ST_MY_DIV,
		ST_MY_WAIT,
		ST_MEAN,
		ST_BX_DIV,
		ST_BX_WAIT,
		ST_BY_DIV,
		ST_BY_WAIT,
		ST_OUT,
		ST_HOLD
	} state_t;

endpackage

[hw/rtl/ir_two_point_tracker.sv]
// ----------------------------------------------------------------------------
// ir_two_point_tracker
// Two-point IR pointer tracker with running mean and blend.
// ----------------------------------------------------------------------------
//  channel | signals                         | dir
//  in      | in_valid/in_ready, pK_x/y/valid | in
//  out     | out_valid/out_ready, found, pos | out
//  cfg     | cfg_we, cfg_idx, cfg_data       | in
// A frame with a usable point is loaded into the output register after two
// passes of the shared serial divider, or four when the blend applies, plus the
// sequencing states; a frame with no usable point skips the divider. in_ready
// is high only in idle, in the cycle after each load; a result waits in the
// output register while the next frame runs, and the sequencer stalls in its
// last state only while it waits.
module ir_two_point_tracker #(
	parameter int SENSOR_MAX_X = 1023,
	parameter int SENSOR_MAX_Y = 767
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [9:0]  p0_x, p0_y,
	input  logic        p0_valid,
	input  logic [9:0]  p1_x, p1_y,
	input  logic        p1_valid,
	input  logic [9:0]  p2_x, p2_y,
	input  logic        p2_valid,
	input  logic [9:0]  p3_x, p3_y,
	input  logic        p3_valid,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [9:0]  pos_x,
	output logic [9:0]  pos_y,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [9:0]  cfg_data
);
	import irtp_pkg::*;

	logic [9:0] radius_q;
	logic [7:0] max_q, min_q, wgt_q;
	logic signed [11:0] ref_x_q, ref_y_q, vec_x_q, vec_y_q, mean_x_q, mean_y_q;
	logic [7:0] cnt_q;
	logic [9:0] held_x_q, held_y_q;
	logic [9:0] px_q [4];
	logic [9:0] py_q [4];
	logic [3:0] ok_q;
	logic [1:0] k_q;
	logic signed [12:0] ax_q, ay_q, bx_q, by_q;
	logic ha_q, hb_q;
	logic signed [13:0] mx_q, my_q;
	logic signed [31:0] blx_q;
	state_t st_q, st_d;

	logic        dv_start;
	logic signed [31:0] dv_num;
	logic [8:0]  dv_den;
	logic        dv_done;
	logic signed [31:0] dv_quo;

	irtp_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .num(dv_num),
		.den(dv_den), .done(dv_done), .quo(dv_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 10'd10;
			max_q    <= 8'd8;
			min_q    <= 8'd4;
			wgt_q    <= 8'd3;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_RADIUS:   radius_q <= cfg_data;
				REG_MAX_SAMP: max_q    <= cfg_data[7:0];
				REG_MIN_SAMP: min_q    <= cfg_data[7:0];
				REG_WEIGHT:   wgt_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// squared distance
	function automatic logic signed [31:0] dsq(input logic signed [13:0] ax,
		input logic signed [13:0] ay, input logic signed [13:0] bx,
		input logic signed [13:0] by);
		logic signed [15:0] dx, dy;
		logic signed [31:0] sqx, sqy;
		dx = 16'(ax) - 16'(bx);
		dy = 16'(ay) - 16'(by);
		sqx = 32'(dx) * 32'(dx);
		sqy = 32'(dy) * 32'(dy);
		return sqx + sqy;
	endfunction

	function automatic logic signed [31:0] dmin(input logic signed [13:0] px,
		input logic signed [13:0] py, input logic signed [13:0] rx,
		input logic signed [13:0] ry, input logic signed [13:0] ex,
		input logic signed [13:0] ey);
		logic signed [31:0] d0, d1;
		d0 = dsq(px, py, rx, ry);
		d1 = dsq(px, py, ex, ey);
		return (d1 < d0) ? d1 : d0;
	endfunction

	logic signed [13:0] ex, ey, rx, ry, cx, cy;
	logic signed [31:0] dc, da, db;
	assign rx = 14'(ref_x_q);
	assign ry = 14'(ref_y_q);
	assign ex = rx + 14'(vec_x_q);
	assign ey = ry + 14'(vec_y_q);
	assign cx = 14'($signed({1'b0, px_q[k_q]}));
	assign cy = 14'($signed({1'b0, py_q[k_q]}));
	assign dc = dmin(cx, cy, rx, ry, ex, ey);
	assign da = dmin(14'(ax_q), 14'(ay_q), rx, ry, ex, ey);
	assign db = dmin(14'(bx_q), 14'(by_q), rx, ry, ex, ey);

	logic signed [13:0] fbx, fby;
	logic signed [31:0] r2, dmean;
	logic signed [13:0] nmx, nmy;
	assign fbx = 14'(ax_q) - 14'(vec_x_q);
	assign fby = 14'(ay_q) - 14'(vec_y_q);
	assign nmx = 14'(mean_x_q);
	assign nmy = 14'(mean_y_q);
	assign r2 = 32'({22'd0, radius_q} * {22'd0, radius_q});
	assign dmean = dsq(mx_q, my_q, nmx, nmy);

	always_comb begin
		st_d     = st_q;
		dv_start = 1'b0;
		dv_num   = '0;
		dv_den   = '0;
		unique case (st_q)
			ST_IDLE: if (in_valid) st_d = ST_SEL;
			ST_SEL: begin
				if (k_q == 2'd3) st_d = ST_PAIR;
			end
			ST_PAIR: st_d = !ha_q ? ST_HOLD : ST_FIX;
			ST_FIX: st_d = ST_MX_DIV;
			ST_MX_DIV: begin
				dv_start = 1'b1;
				dv_num = 32'(mean_x_q) * $signed({24'd0, cnt_q}) + 32'(mx_q);
				dv_den = {1'b0, cnt_q} + 9'd1;
				st_d = ST_MX_WAIT;
			end
			ST_MX_WAIT: if (dv_done) st_d = ST_MY_DIV;
			ST_MY_DIV: begin
				dv_start = 1'b1;
				dv_num = 32'(mean_y_q) * $signed({24'd0, cnt_q}) + 32'(my_q);
				dv_den = {1'b0, cnt_q} + 9'd1;
				st_d = ST_MY_WAIT;
			end
			ST_MY_WAIT: if (dv_done) st_d = ST_MEAN;
			ST_MEAN: begin
				if (dmean < r2 && cnt_q >= min_q) st_d = ST_BX_DIV;
				else st_d = ST_OUT;
			end
			ST_BX_DIV: begin
				dv_start = 1'b1;
				dv_num = 32'(mx_q) + 32'(mean_x_q) * $signed({24'd0, wgt_q});
				dv_den = {1'b0, wgt_q} + 9'd1;
				st_d = ST_BX_WAIT;
			end
			ST_BX_WAIT: if (dv_done) st_d = ST_BY_DIV;
			ST_BY_DIV: begin
				dv_start = 1'b1;
				dv_num = 32'(my_q) + 32'(mean_y_q) * $signed({24'd0, wgt_q});
				dv_den = {1'b0, wgt_q} + 9'd1;
				st_d = ST_BY_WAIT;
			end
			ST_BY_WAIT: if (dv_done) st_d = ST_OUT;
			ST_OUT, ST_HOLD: if (!out_valid || out_ready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	assign in_ready = (st_q == ST_IDLE);

	logic out_load;
	assign out_load = (st_q == ST_OUT || st_q == ST_HOLD) && (!out_valid || out_ready);

	logic signed [31:0] cx32, cy32;
	assign cx32 = 32'(SENSOR_MAX_X) - ((st_q == ST_BY_WAIT) ? blx_q : 32'(mx_q));
	assign cy32 = (st_q == ST_BY_WAIT) ? dv_quo : 32'(my_q);
	logic [9:0] ox, oy;
	assign ox = (cx32 < 0) ? 10'd0 : (cx32 > SENSOR_MAX_X) ? 10'(SENSOR_MAX_X) : cx32[9:0];
	assign oy = (cy32 < 0) ? 10'd0 : (cy32 > SENSOR_MAX_Y) ? 10'(SENSOR_MAX_Y) : cy32[9:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_x_q <= '0; ref_y_q <= '0; vec_x_q <= '0; vec_y_q <= '0;
			mean_x_q <= '0; mean_y_q <= '0; cnt_q <= '0;
			held_x_q <= '0; held_y_q <= '0;
			out_valid <= 1'b0;
			found <= 1'b0; pos_x <= '0; pos_y <= '0;
			k_q <= '0;
			ha_q <= 1'b0; hb_q <= 1'b0;
			ax_q <= '0; ay_q <= '0; bx_q <= '0; by_q <= '0;
			mx_q <= '0; my_q <= '0;
			blx_q <= '0;
		end else begin
			if (out_load) begin
				found <= (st_q == ST_OUT);
				pos_x <= held_x_q; pos_y <= held_y_q;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					k_q <= '0; ha_q <= 1'b0; hb_q <= 1'b0;
				end
				ST_SEL: begin
					k_q <= k_q + 2'd1;
					if (ok_q[k_q]) begin
						if (!ha_q) begin
							ax_q <= 13'(cx); ay_q <= 13'(cy); ha_q <= 1'b1;
						end else if (!hb_q) begin
							bx_q <= 13'(cx); by_q <= 13'(cy); hb_q <= 1'b1;
						end else if (dc < da) begin
							if (db < da) begin
								ax_q <= 13'(cx); ay_q <= 13'(cy);
							end else begin
								bx_q <= 13'(cx); by_q <= 13'(cy);
							end
						end else if (dc < db) begin
							bx_q <= 13'(cx); by_q <= 13'(cy);
						end
					end
				end
				ST_PAIR: begin
					if (ha_q && !hb_q) begin
						if (dsq(14'(ax_q), 14'(ay_q), rx, ry) < dsq(fbx, fby, rx, ry)) begin
							bx_q <= 13'(ax_q) + 13'(vec_x_q);
							by_q <= 13'(ay_q) + 13'(vec_y_q);
							ref_x_q <= ax_q[11:0]; ref_y_q <= ay_q[11:0];
						end else begin
							bx_q <= fbx[12:0]; by_q <= fby[12:0];
							ref_x_q <= fbx[11:0]; ref_y_q <= fby[11:0];
						end
					end else if (ha_q) begin
						vec_x_q <= 12'(bx_q - ax_q); vec_y_q <= 12'(by_q - ay_q);
						ref_x_q <= ax_q[11:0]; ref_y_q <= ay_q[11:0];
					end
				end
				ST_FIX: begin
					mx_q <= 14'((ax_q + bx_q) / 2);
					my_q <= 14'((ay_q + by_q) / 2);
				end
				ST_MX_WAIT: if (dv_done) mean_x_q <= dv_quo[11:0];
				ST_MY_WAIT: if (dv_done) begin
					mean_y_q <= dv_quo[11:0];
					cnt_q <= ({1'b0, cnt_q} + 9'd1 > {1'b0, max_q}) ? max_q : cnt_q + 8'd1;
				end
				ST_MEAN: begin
					if (!(dmean < r2)) cnt_q <= '0;
					if (!(dmean < r2 && cnt_q >= min_q)) begin
						held_x_q <= ox; held_y_q <= oy;
					end
				end
				ST_BX_WAIT: if (dv_done) blx_q <= dv_quo;
				ST_BY_WAIT: if (dv_done) begin
					held_x_q <= ox; held_y_q <= oy;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			px_q[0] <= p0_x; py_q[0] <= p0_y;
			px_q[1] <= p1_x; py_q[1] <= p1_y;
			px_q[2] <= p2_x; py_q[2] <= p2_y;
			px_q[3] <= p3_x; py_q[3] <= p3_y;
			ok_q <= {p3_valid && (p3_x != 0 || p3_y != 0),
				p2_valid && (p2_x != 0 || p2_y != 0),
				p1_valid && (p1_x != 0 || p1_y != 0),
				p0_valid && (p0_x != 0 || p0_y != 0)};
		end
	end
endmodule

[hw/rtl/irtp_div.sv]
// ----------------------------------------------------------------------------
// irtp_div
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module irtp_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [31:0]  num,
	input  logic        [8:0]   den,
	output logic                done,
	output logic signed [31:0]  quo
);
	import irtp_pkg::*;

	logic [31:0] rem_q;
	logic [31:0] q_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        neg_q;
	logic [8:0]  den_q;
	logic [31:0] trial;
	logic [31:0] shifted;

	assign shifted = {rem_q[30:0], q_q[31]};
	assign trial   = shifted - {23'd0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[31];
			q_q   <= num[31] ? 32'(-num) : 32'(num);
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[31]) begin
				rem_q <= trial;
				q_q   <= {q_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted;
				q_q   <= {q_q[30:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? -$signed(q_q) : $signed(q_q);
endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ir_two_point_tracker testbench
// Drives camera frames through the input channel with random gaps, takes
// results with random stalls and compares each against an in-bench model of
// point selection, pair rebuild, running mean and blend. Registers are
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
	import irtp_pkg::*;

	typedef struct {
		logic [9:0] x[4];
		logic [9:0] y[4];
		logic       v[4];
	} frame_t;

	typedef struct {
		logic       found;
		logic [9:0] pos_x;
		logic [9:0] pos_y;
	} pointer_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [9:0] p0_x = 0, p0_y = 0, p1_x = 0, p1_y = 0;
	logic [9:0] p2_x = 0, p2_y = 0, p3_x = 0, p3_y = 0;
	logic p0_valid = 0, p1_valid = 0, p2_valid = 0, p3_valid = 0;
	logic out_valid;
	logic out_ready = 0;
	logic found;
	logic [9:0] pos_x, pos_y;
	logic cfg_we = 0;
	logic [1:0] cfg_idx = 0;
	logic [9:0] cfg_data = 0;

	ir_two_point_tracker u_top (.*);

	frame_t   frame_q[$];
	pointer_t pointer_q[$];
	int       n_errors = 0;
	bit       hold_frames = 0;

	// tracker state
	longint radius, max_samp, min_samp, weight;
	logic [11:0] ref_x, ref_y, vec_x, vec_y, mean_x, mean_y;
	logic [7:0]  mean_cnt;
	logic [9:0]  held_x, held_y;

	initial forever #4 clk = ~clk;

	function automatic longint sx(logic [11:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint dist2(longint ax, longint ay, longint bx, longint by);
		return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
	endfunction

	function automatic longint clip(longint v, longint hi);
		return v < 0 ? 0 : (v > hi ? hi : v);
	endfunction

	task automatic track_frame(input frame_t f);
		longint ax = 0, ay = 0, bx = 0, by = 0, cx, cy, rx, ry, vx, vy, ex, ey;
		longint da, db, dc, mx, my, cnt, qx, qy, t;
		bit ha = 0, hb = 0;
		longint nc;
		pointer_t r;
		rx = sx(ref_x); ry = sx(ref_y); vx = sx(vec_x); vy = sx(vec_y);
		for (int i = 0; i < 4; i++) begin
			if (!f.v[i] || (f.x[i] == 0 && f.y[i] == 0)) continue;
			cx = f.x[i]; cy = f.y[i];
			if (!ha) begin
				ax = cx; ay = cy; ha = 1;
			end else if (!hb) begin
				bx = cx; by = cy; hb = 1;
			end else begin
				ex = rx + vx; ey = ry + vy;
				dc = dist2(cx, cy, rx, ry); t = dist2(cx, cy, ex, ey); if (t < dc) dc = t;
				da = dist2(ax, ay, rx, ry); t = dist2(ax, ay, ex, ey); if (t < da) da = t;
				db = dist2(bx, by, rx, ry); t = dist2(bx, by, ex, ey); if (t < db) db = t;
				if (dc < da) begin
					if (db < da) begin
						ax = cx; ay = cy;
					end else begin
						bx = cx; by = cy;
					end
				end else if (dc < db) begin
					bx = cx; by = cy;
				end
			end
		end
		if (!ha) begin
			r.found = 0; r.pos_x = held_x; r.pos_y = held_y;
			pointer_q.push_back(r);
			return;
		end
		if (!hb) begin
			bx = ax - vx; by = ay - vy;
			if (dist2(ax, ay, rx, ry) < dist2(bx, by, rx, ry)) begin
				bx = ax + vx; by = ay + vy;
				ref_x = ax[11:0]; ref_y = ay[11:0];
			end else begin
				ref_x = bx[11:0]; ref_y = by[11:0];
			end
		end else begin
			t = bx - ax; vec_x = t[11:0];
			t = by - ay; vec_y = t[11:0];
			ref_x = ax[11:0]; ref_y = ay[11:0];
		end
		mx = (ax + bx) / 2; my = (ay + by) / 2;
		cnt = mean_cnt;
		t = (sx(mean_x) * cnt + mx) / (cnt + 1); mean_x = t[11:0];
		t = (sx(mean_y) * cnt + my) / (cnt + 1); mean_y = t[11:0];
		nc = mean_cnt + 1;
		if (nc > max_samp) nc = max_samp;
		mean_cnt = nc[7:0];
		qx = mx; qy = my;
		if (dist2(mx, my, sx(mean_x), sx(mean_y)) < radius * radius) begin
			if (mean_cnt >= min_samp) begin
				qx = (mx + sx(mean_x) * weight) / (weight + 1);
				qy = (my + sx(mean_y) * weight) / (weight + 1);
			end
		end else begin
			mean_cnt = 0;
		end
		t = clip(1023 - qx, 1023); held_x = t[9:0];
		t = clip(qy, 767); held_y = t[9:0];
		r.found = 1; r.pos_x = held_x; r.pos_y = held_y;
		pointer_q.push_back(r);
	endtask

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		n_errors++;
	endtask

	// driver
	int in_gap = 0;
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_valid <= 0;
			in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
		end else if (!in_valid && frame_q.size() > 0 && !hold_frames) begin
			if (in_gap > 0) begin
				in_gap--;
			end else begin
				frame_t f;
				f = frame_q.pop_front();
				track_frame(f);
				{p0_x, p0_y, p0_valid} <= {f.x[0], f.y[0], f.v[0]};
				{p1_x, p1_y, p1_valid} <= {f.x[1], f.y[1], f.v[1]};
				{p2_x, p2_y, p2_valid} <= {f.x[2], f.y[2], f.v[2]};
				{p3_x, p3_y, p3_valid} <= {f.x[3], f.y[3], f.v[3]};
				in_valid <= 1;
			end
		end
	end

	// monitor
	int out_gap = 0;
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (pointer_q.size() == 0) begin
				report("unexpected transfer", 1, 0);
			end else begin
				pointer_t e;
				e = pointer_q.pop_front();
				if (found !== e.found) report("found", found, e.found);
				if (pos_x !== e.pos_x) report("pos_x", pos_x, e.pos_x);
				if (pos_y !== e.pos_y) report("pos_y", pos_y, e.pos_y);
			end
			out_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
			out_ready <= out_gap == 0;
		end else if (out_gap > 0) begin
			out_gap--;
			out_ready <= out_gap == 0;
		end else begin
			out_ready <= 1;
		end
	end

	function automatic frame_t rand_frame(input int mode, input longint cx, input longint cy);
		frame_t f;
		longint tx, ty;
		for (int i = 0; i < 4; i++) begin
			if (mode == 0) begin
				f.x[i] = 10'($urandom); f.y[i] = 10'($urandom);
			end else begin
				tx = cx + $signed($urandom_range(0, 40)) - 20 + (i % 2) * 120;
				ty = cy + $signed($urandom_range(0, 40)) - 20;
				f.x[i] = tx[9:0]; f.y[i] = ty[9:0];
				if ($urandom_range(0, 9) == 0) begin
					f.x[i] = 0; f.y[i] = 0;
				end
			end
			f.v[i] = mode == 0 ? 1'($urandom_range(0, 1)) :
				(i < 2 || $urandom_range(0, 3) == 0);
			if (mode == 2 && i == 1) f.v[i] = 1'($urandom_range(0, 1));
		end
		return f;
	endfunction

	task automatic drain();
		wait (frame_q.size() == 0 && !in_valid && pointer_q.size() == 0);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [9:0] val);
		@(posedge clk);
		cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_RADIUS:   radius = val;
			REG_MAX_SAMP: max_samp = val[7:0];
			REG_MIN_SAMP: min_samp = val[7:0];
			REG_WEIGHT:   weight = val[7:0];
		endcase
	endtask

	initial begin
		frame_t f;
		longint cx, cy;
		radius = 10; max_samp = 8; min_samp = 4; weight = 3;
		ref_x = 0; ref_y = 0; vec_x = 0; vec_y = 0;
		mean_x = 0; mean_y = 0; mean_cnt = 0; held_x = 0; held_y = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed frames
		f = rand_frame(1, 500, 400); frame_q.push_back(f);
		for (int i = 0; i < 4; i++) begin
			f.v[i] = 0;
		end
		frame_q.push_back(f);
		for (int i = 0; i < 4; i++) begin
			f.x[i] = 0; f.y[i] = 0; f.v[i] = 1;
		end
		frame_q.push_back(f);
		f.x[0] = 1023; f.y[0] = 1023; f.x[1] = 0; f.y[1] = 1;
		f.x[2] = 1; f.y[2] = 0; f.x[3] = 1023; f.y[3] = 0;
		frame_q.push_back(f);
		f.v[1] = 0; f.v[2] = 0; f.v[3] = 0; frame_q.push_back(f);
		f.x[0] = 0; f.y[0] = 767; frame_q.push_back(f);
		for (int k = 0; k < 10; k++) begin
			f = rand_frame(1, 300, 300); frame_q.push_back(f);
		end
		for (int k = 0; k < 4; k++) begin
			f = rand_frame(1, 300, 300); f.v[1] = 0; f.v[2] = 0; f.v[3] = 0;
			frame_q.push_back(f);
		end
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					write_reg(REG_RADIUS, 1023); write_reg(REG_MAX_SAMP, 255);
					write_reg(REG_MIN_SAMP, 1); write_reg(REG_WEIGHT, 255);
				end
				1: begin
					write_reg(REG_RADIUS, 0); write_reg(REG_MAX_SAMP, 1);
					write_reg(REG_MIN_SAMP, 255); write_reg(REG_WEIGHT, 0);
				end
				2: begin
					write_reg(REG_RADIUS, 0); write_reg(REG_MAX_SAMP, 0);
					write_reg(REG_MIN_SAMP, 0); write_reg(REG_WEIGHT, 7);
				end
				default: begin
					write_reg(REG_RADIUS, 10'($urandom_range(0, 1023)));
					write_reg(REG_MAX_SAMP, 10'($urandom_range(0, 255)));
					write_reg(REG_MIN_SAMP, 10'($urandom_range(0, 255)));
					write_reg(REG_WEIGHT, 10'($urandom_range(0, 255)));
				end
			endcase
			cx = $urandom_range(30, 850); cy = $urandom_range(30, 740);
			for (int k = 0; k < 180; k++) begin
				if ($urandom_range(0, 19) == 0) begin
					cx = $urandom_range(0, 900); cy = $urandom_range(0, 767);
				end
				cx = clip(cx + $signed($urandom_range(0, 6)) - 3, 900);
				f = rand_frame($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 2), cx, cy);
				frame_q.push_back(f);
			end
			if (phase == 3) begin
				wait (frame_q.size() <= 90);
				hold_frames = 1;
				wait (pointer_q.size() == 0 && !in_valid);
				@(posedge clk);
				hold_frames = 0;
			end
			drain();
		end

		if (n_errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
